### rtl/ntip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntip_pkg: shared types, constants and arithmetic helpers
// Widths, register indexes, queue item layout and Q30 helper functions for
// the target-to-image projection unit.
// ----------------------------------------------------------------------------
package ntip_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  localparam int POS_W   = 31;
  localparam int DIFF_W  = 32;
  localparam int HEAD_W  = 16;
  localparam int HGT_W   = 21;
  localparam int ALT_W   = 20;
  localparam int CFG_W   = 16;
  localparam int OUT_W   = 24;
  localparam int IDX_W   = 2;
  localparam int Q_W     = 31;
  localparam int A_W     = 30;
  localparam int OCT_W   = 3;
  localparam int PROD_W  = 64;
  localparam int MAG_W   = 63;
  localparam int SC_LAT  = 9;

  localparam logic [Q_W-1:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [Q_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [A_W-1:0] OCT_SPAN    = 30'h2000_0000;

  localparam logic [29:0] RECIP_42 = 30'((64'd1 << 31) / 42);
  localparam logic [29:0] RECIP_20 = 30'((64'd1 << 31) / 20);
  localparam logic [29:0] RECIP_6  = 30'((64'd1 << 31) / 6);
  localparam logic [29:0] RECIP_56 = 30'((64'd1 << 31) / 56);
  localparam logic [29:0] RECIP_30 = 30'((64'd1 << 31) / 30);
  localparam logic [29:0] RECIP_12 = 30'((64'd1 << 31) / 12);

  localparam logic [CFG_W-1:0] FOCAL_RST   = 16'd9600;
  localparam logic [CFG_W-1:0] MIN_ALT_RST = 16'd50;

  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X = 2'd0,
    REG_FOCAL_Y = 2'd1,
    REG_MIN_ALT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dn;
    logic signed [DIFF_W-1:0] de;
    logic [ALT_W-1:0]         alt;
    logic [OCT_W-1:0]         oct;
    logic [A_W-1:0]           a;
  } item_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dn;
    logic signed [DIFF_W-1:0] de;
    logic [ALT_W-1:0]         alt;
  } side_t;

  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
  } focal_t;

  // floor(v / d) for v < 2^31 through a 2^-31 scaled reciprocal, one fixup
  function automatic logic [Q_W-1:0] div_const(input logic [Q_W-1:0] v,
                                               input logic [5:0] d,
                                               input logic [29:0] recip);
    logic [60:0]    prod;
    logic [Q_W-1:0] q;
    logic [36:0]    qd;
    logic [Q_W-1:0] rem;
    prod = 61'(v) * 61'(recip);
    q    = {1'b0, prod[60:31]};
    qd   = 37'(q) * 37'(d);
    rem  = v - qd[Q_W-1:0];
    if (rem >= 31'(d)) begin
      q = q + 31'd1;
    end
    return q;
  endfunction

  function automatic logic [Q_W-1:0] mq30(input logic [Q_W-1:0] a,
                                          input logic [Q_W-1:0] b);
    logic [61:0] prod;
    prod = 62'(a) * 62'(b);
    return prod[60:30];
  endfunction

endpackage
`default_nettype wire

### rtl/ntip_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntip_front: request intake and classification
// Forms position differences, the clamped altitude and the octant fold of
// the heading, and holds the result in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ntip_front #(
  parameter int ANGLE_BITS = ntip_pkg::ANGLE_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [ntip_pkg::POS_W-1:0]      goal_north_i,
  input  wire  [ntip_pkg::POS_W-1:0]      goal_east_i,
  input  wire  [ntip_pkg::POS_W-1:0]      craft_north_i,
  input  wire  [ntip_pkg::POS_W-1:0]      craft_east_i,
  input  wire  [ntip_pkg::HEAD_W-1:0]     heading_i,
  input  wire  [ntip_pkg::HGT_W-1:0]      height_i,
  input  wire  [ntip_pkg::CFG_W-1:0]      min_alt_i,
  input  wire                             pop_i,
  output logic                            item_valid_o,
  output ntip_pkg::item_t                 item_o
);

  localparam int DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  ntip_pkg::item_t             item_d;
  ntip_pkg::item_t             mem_q [2];
  logic                        wr_ptr_q, wr_ptr_d;
  logic                        rd_ptr_q, rd_ptr_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic                        push, pop, full;
  logic [ntip_pkg::HEAD_W-1:0] hd_m;
  logic [28:0]                 r;
  logic [ntip_pkg::CFG_W-1:0]  floor_alt;

  always_comb begin
    hd_m        = (heading_i >> DROP) << DROP;
    r           = {hd_m[12:0], 16'b0};
    item_d.oct  = hd_m[15:13];
    item_d.a    = hd_m[13] ? (ntip_pkg::OCT_SPAN - {1'b0, r}) : {1'b0, r};
    item_d.dn   = $signed({goal_north_i[30], goal_north_i})
                - $signed({craft_north_i[30], craft_north_i});
    item_d.de   = $signed({goal_east_i[30], goal_east_i})
                - $signed({craft_east_i[30], craft_east_i});
    floor_alt   = (min_alt_i == '0) ? 16'd1 : min_alt_i;
    if ($signed(height_i) > $signed({5'b0, floor_alt})) begin
      item_d.alt = height_i[ntip_pkg::ALT_W-1:0];
    end else begin
      item_d.alt = {4'b0, floor_alt};
    end
  end

  assign full         = (cnt_q == 2'd2);
  assign in_stall_o   = full;
  assign push         = in_valid_i && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");

endmodule
`default_nettype wire

### rtl/ntip_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntip_sincos: pipelined sine and cosine
// Taylor series in unsigned Q30 over one octant, one product or one
// constant division per stage, then octant unfold into signed Q30.
// ----------------------------------------------------------------------------
module ntip_sincos (
  input  wire                              clk_i,
  input  wire                              en_i,
  input  wire  [ntip_pkg::OCT_W-1:0]       oct_i,
  input  wire  [ntip_pkg::A_W-1:0]         a_i,
  output logic signed [ntip_pkg::DIFF_W-1:0] sin_o,
  output logic signed [ntip_pkg::DIFF_W-1:0] cos_o
);

  localparam int QW = ntip_pkg::Q_W;
  localparam int OW = ntip_pkg::OCT_W;

  logic [60:0]   xa;
  logic [59:0]   xsq;
  logic [QW-1:0] x1_q, x2_q, x3_q, x4_q, x5_q, x6_q, x7_q;
  logic [QW-1:0] xx2_q, xx3_q, xx4_q, xx5_q, xx6_q, xx7_q;
  logic [OW-1:0] oct1_q, oct2_q, oct3_q, oct4_q, oct5_q, oct6_q, oct7_q, oct8_q;
  logic [QW-1:0] ts3_q, tc3_q, ps4_q, pc4_q, ts5_q, tc5_q;
  logic [QW-1:0] ps6_q, pc6_q, ts7_q, tc7_q, s8_q, pc8_q;
  logic [QW-1:0] c0;
  logic signed [ntip_pkg::DIFF_W-1:0] s, c, sn_d, cs_d, sin_q, cos_q;

  assign xa  = 61'(a_i) * 61'(ntip_pkg::HALF_PI_Q30);
  assign xsq = 60'(x1_q) * 60'(x1_q);

  always_comb begin
    c0 = ntip_pkg::ONE_Q30 - (pc8_q >> 1);
    s  = $signed({1'b0, s8_q});
    c  = $signed({1'b0, c0});
    unique case (oct8_q)
      3'd0:    begin sn_d = s;  cs_d = c;  end
      3'd1:    begin sn_d = c;  cs_d = s;  end
      3'd2:    begin sn_d = c;  cs_d = -s; end
      3'd3:    begin sn_d = s;  cs_d = -c; end
      3'd4:    begin sn_d = -s; cs_d = -c; end
      3'd5:    begin sn_d = -c; cs_d = -s; end
      3'd6:    begin sn_d = -c; cs_d = s;  end
      default: begin sn_d = -s; cs_d = c;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= xa[60:30];
      oct1_q <= oct_i;

      x2_q   <= x1_q;
      xx2_q  <= {1'b0, xsq[59:30]};
      oct2_q <= oct1_q;

      x3_q   <= x2_q;
      xx3_q  <= xx2_q;
      oct3_q <= oct2_q;
      ts3_q  <= ntip_pkg::ONE_Q30 - ntip_pkg::div_const(xx2_q, 6'd42, ntip_pkg::RECIP_42);
      tc3_q  <= ntip_pkg::ONE_Q30 - ntip_pkg::div_const(xx2_q, 6'd56, ntip_pkg::RECIP_56);

      x4_q   <= x3_q;
      xx4_q  <= xx3_q;
      oct4_q <= oct3_q;
      ps4_q  <= ntip_pkg::mq30(xx3_q, ts3_q);
      pc4_q  <= ntip_pkg::mq30(xx3_q, tc3_q);

      x5_q   <= x4_q;
      xx5_q  <= xx4_q;
      oct5_q <= oct4_q;
      ts5_q  <= ntip_pkg::ONE_Q30 - ntip_pkg::div_const(ps4_q, 6'd20, ntip_pkg::RECIP_20);
      tc5_q  <= ntip_pkg::ONE_Q30 - ntip_pkg::div_const(pc4_q, 6'd30, ntip_pkg::RECIP_30);

      x6_q   <= x5_q;
      xx6_q  <= xx5_q;
      oct6_q <= oct5_q;
      ps6_q  <= ntip_pkg::mq30(xx5_q, ts5_q);
      pc6_q  <= ntip_pkg::mq30(xx5_q, tc5_q);

      x7_q   <= x6_q;
      xx7_q  <= xx6_q;
      oct7_q <= oct6_q;
      ts7_q  <= ntip_pkg::ONE_Q30 - ntip_pkg::div_const(ps6_q, 6'd6, ntip_pkg::RECIP_6);
      tc7_q  <= ntip_pkg::ONE_Q30 - ntip_pkg::div_const(pc6_q, 6'd12, ntip_pkg::RECIP_12);

      oct8_q <= oct7_q;
      s8_q   <= ntip_pkg::mq30(x7_q, ts7_q);
      pc8_q  <= ntip_pkg::mq30(xx7_q, tc7_q);

      sin_q  <= sn_d;
      cos_q  <= cs_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

### rtl/ntip_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntip_div: pipelined restoring divider
// One quotient bit per stage; unsigned magnitude over a positive divisor,
// sign carried alongside.
// ----------------------------------------------------------------------------
module ntip_div (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  [ntip_pkg::MAG_W-1:0]   mag_i,
  input  wire  [ntip_pkg::ALT_W-1:0]   den_i,
  input  wire                          neg_i,
  output logic [ntip_pkg::MAG_W-1:0]   quo_o,
  output logic                         neg_o
);

  localparam int MW = ntip_pkg::MAG_W;
  localparam int DW = ntip_pkg::ALT_W;

  logic [DW-1:0] rem_q [MW];
  logic [MW-1:0] nq_q  [MW];
  logic [DW-1:0] den_q [MW];
  logic          neg_q [MW];

  for (genvar i = 0; i < MW; i++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [MW-1:0] nq_in;
    logic          neg_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = mag_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign nq_in  = nq_q[i-1];
      assign den_in = den_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign t    = {rem_in, nq_in[MW-1]};
    assign diff = t - {1'b0, den_in};
    assign ge   = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nq_q[i]  <= {nq_in[MW-2:0], ge};
        den_q[i] <= den_in;
        neg_q[i] <= neg_in;
      end
    end
  end

  assign quo_o = nq_q[MW-1];
  assign neg_o = neg_q[MW-1];

endmodule
`default_nettype wire

### rtl/ntip_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntip_back: projection pipeline
// Sine/cosine, yaw rotation, division by altitude, focal scaling and
// saturation; the whole pipe advances unless a finished result is stalled.
// ----------------------------------------------------------------------------
module ntip_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              item_valid_i,
  input  ntip_pkg::item_t                  item_i,
  output logic                             pop_o,
  input  ntip_pkg::focal_t                 focal_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [ntip_pkg::OUT_W-1:0]       image_x_o,
  output logic [ntip_pkg::OUT_W-1:0]       image_y_o
);

  localparam int SL = ntip_pkg::SC_LAT;
  localparam int N  = 1 + SL + 3 + ntip_pkg::MAG_W + 2;
  localparam int PW = ntip_pkg::PROD_W;
  localparam int MW = ntip_pkg::MAG_W;
  localparam int OW = ntip_pkg::OUT_W;

  logic                  en;
  logic [N-1:0]          v_q;
  ntip_pkg::item_t       s0_q;
  ntip_pkg::side_t       side_q [SL];
  logic signed [ntip_pkg::DIFF_W-1:0] sn, cs;
  logic signed [PW-1:0]  p_cn_q, p_sd_q, p_ce_q, p_sn_q;
  logic [ntip_pkg::ALT_W-1:0] alt1_q, alt2_q, alt3_q;
  logic signed [PW-1:0]  fwd_q, rgt_q;
  logic [MW-1:0]         mag_x_q, mag_y_q;
  logic                  neg_x_q, neg_y_q;
  logic [MW-1:0]         quo_x, quo_y;
  logic                  dneg_x, dneg_y;
  logic [48:0]           hi_x_q, hi_y_q;
  logic [45:0]           lo_x, lo_y;
  logic [15:0]           lt_x_q, lt_y_q;
  logic                  sneg_x_q, sneg_y_q;
  logic [OW-1:0]         img_x_q, img_y_q;

  function automatic logic [OW-1:0] sat(input logic [48:0] hi,
                                        input logic [15:0] lt,
                                        input logic neg);
    logic [49:0] p;
    p = 50'(hi) + 50'(lt);
    if (neg) begin
      sat = (p >= 50'h80_0000) ? 24'h80_0000 : 24'(-p[OW-1:0]);
    end else begin
      sat = (p > 50'h7F_FFFF) ? 24'h7F_FFFF : p[OW-1:0];
    end
  endfunction

  assign en    = !(v_q[N-1] && out_stall_i);
  assign pop_o = en && item_valid_i;

  ntip_sincos u_sincos (
    .clk_i (clk_i),
    .en_i  (en),
    .oct_i (s0_q.oct),
    .a_i   (s0_q.a),
    .sin_o (sn),
    .cos_o (cs)
  );

  ntip_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_x_q),
    .den_i (alt3_q),
    .neg_i (neg_x_q),
    .quo_o (quo_x),
    .neg_o (dneg_x)
  );

  ntip_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (mag_y_q),
    .den_i (alt3_q),
    .neg_i (neg_y_q),
    .quo_o (quo_y),
    .neg_o (dneg_y)
  );

  assign lo_x = 46'(quo_x[29:0]) * 46'(focal_i.focal_x);
  assign lo_y = 46'(quo_y[29:0]) * 46'(focal_i.focal_y);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= item_i;
      side_q[0] <= '{dn: s0_q.dn, de: s0_q.de, alt: s0_q.alt};
      for (int i = 1; i < SL; i++) begin
        side_q[i] <= side_q[i-1];
      end

      p_cn_q <= PW'(cs) * PW'(side_q[SL-1].dn);
      p_sd_q <= PW'(sn) * PW'(side_q[SL-1].de);
      p_ce_q <= PW'(cs) * PW'(side_q[SL-1].de);
      p_sn_q <= PW'(sn) * PW'(side_q[SL-1].dn);
      alt1_q <= side_q[SL-1].alt;

      fwd_q  <= p_cn_q + p_sd_q;
      rgt_q  <= p_ce_q - p_sn_q;
      alt2_q <= alt1_q;

      neg_x_q <= rgt_q[PW-1];
      mag_x_q <= rgt_q[PW-1] ? MW'(-rgt_q) : rgt_q[MW-1:0];
      neg_y_q <= fwd_q[PW-1];
      mag_y_q <= fwd_q[PW-1] ? MW'(-fwd_q) : fwd_q[MW-1:0];
      alt3_q  <= alt2_q;

      hi_x_q   <= 49'(quo_x[MW-1:30]) * 49'(focal_i.focal_x);
      hi_y_q   <= 49'(quo_y[MW-1:30]) * 49'(focal_i.focal_y);
      lt_x_q   <= lo_x[45:30];
      lt_y_q   <= lo_y[45:30];
      sneg_x_q <= dneg_x;
      sneg_y_q <= dneg_y;

      img_x_q <= sat(hi_x_q, lt_x_q, sneg_x_q);
      img_y_q <= sat(hi_y_q, lt_y_q, sneg_y_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], item_valid_i};
    end
  end

  assign out_valid_o = v_q[N-1];
  assign image_x_o   = img_x_q;
  assign image_y_o   = img_y_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q)) else $error("pipe moved while held");

  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> v_q[N-1:1] == $past(v_q[N-2:0])) else $error("request lost in pipe");

endmodule
`default_nettype wire

### rtl/ned_target_to_image_projection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ned_target_to_image_projection_unit: pinhole projection of a ground target
// Input channel (in_valid_i / in_stall_o) takes one request per cycle with
// target and vehicle north/east positions, heading and height. Output
// channel (out_valid_o / out_stall_i) returns image_x / image_y in pixels
// with 4 fraction bits, saturated. One result per request, in order.
// Throughput: one request per clock while no result is stalled. A request
// passes the queue, the 9-stage sine/cosine pipe, the rotation stages, the
// 63-stage divider and the scaling and saturation stages to out_valid_o.
// A two-entry queue decouples intake from the pipeline. While a finished
// result is stalled the pipeline holds; the queue still takes requests
// until full, then in_stall_o rises.
// Configuration writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) load focal_x,
// focal_y and min_altitude; write only while no request is in flight.
// Reset clears the pipeline and queue and loads focal 9600, min altitude 50.
// ----------------------------------------------------------------------------
module ned_target_to_image_projection_unit #(
  parameter int ANGLE_BITS = ntip_pkg::ANGLE_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [ntip_pkg::IDX_W-1:0]    cfg_addr_i,
  input  wire  [ntip_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [ntip_pkg::POS_W-1:0]    goal_north_i,
  input  wire  [ntip_pkg::POS_W-1:0]    goal_east_i,
  input  wire  [ntip_pkg::POS_W-1:0]    craft_north_i,
  input  wire  [ntip_pkg::POS_W-1:0]    craft_east_i,
  input  wire  [ntip_pkg::HEAD_W-1:0]   heading_i,
  input  wire  [ntip_pkg::HGT_W-1:0]    height_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [ntip_pkg::OUT_W-1:0]    image_x_o,
  output logic [ntip_pkg::OUT_W-1:0]    image_y_o
);

  ntip_pkg::focal_t             focal_q, focal_d;
  logic [ntip_pkg::CFG_W-1:0]   min_alt_q, min_alt_d;
  logic                         pop;
  logic                         item_valid;
  ntip_pkg::item_t              item;

  always_comb begin
    focal_d   = focal_q;
    min_alt_d = min_alt_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ntip_pkg::REG_FOCAL_X: focal_d.focal_x = cfg_wdata_i;
        ntip_pkg::REG_FOCAL_Y: focal_d.focal_y = cfg_wdata_i;
        ntip_pkg::REG_MIN_ALT: min_alt_d       = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q.focal_x <= ntip_pkg::FOCAL_RST;
      focal_q.focal_y <= ntip_pkg::FOCAL_RST;
      min_alt_q       <= ntip_pkg::MIN_ALT_RST;
    end else begin
      focal_q   <= focal_d;
      min_alt_q <= min_alt_d;
    end
  end

  ntip_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .goal_north_i  (goal_north_i),
    .goal_east_i   (goal_east_i),
    .craft_north_i (craft_north_i),
    .craft_east_i  (craft_east_i),
    .heading_i     (heading_i),
    .height_i      (height_i),
    .min_alt_i     (min_alt_q),
    .pop_i         (pop),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  ntip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .focal_i      (focal_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .image_x_o    (image_x_o),
    .image_y_o    (image_y_o)
  );

endmodule
`default_nettype wire

### sim/tb_ned_target_to_image_projection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ned_target_to_image_projection_unit: self-checking bench
// Drives pose requests through the projection unit with random idling on both
// sides, predicts image_x / image_y in fixed point at the moment each request
// is accepted, and checks every result in order across several register
// settings, including zero and full-scale focal lengths and minimum altitudes.
// ----------------------------------------------------------------------------
module tb_ned_target_to_image_projection_unit;

  localparam logic [ntip_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned Q30_HPI  = 64'd1686629713;
  localparam longint unsigned OCT_FULL = 64'd1 << 29;
  localparam int SAT_MAG = 8388608;

  typedef struct packed {
    logic signed [30:0] gn;
    logic signed [30:0] ge;
    logic signed [30:0] cn;
    logic signed [30:0] ce;
    logic [15:0]        hd;
    logic signed [20:0] hgt;
  } pose_t;

  typedef struct packed {
    logic [ntip_pkg::OUT_W-1:0] x;
    logic [ntip_pkg::OUT_W-1:0] y;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [ntip_pkg::IDX_W-1:0] cfg_addr = ntip_pkg::REG_FOCAL_X;
  logic [ntip_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  pose_t cur = '0;
  logic in_stall, out_valid;
  logic [ntip_pkg::OUT_W-1:0] img_x, img_y;

  longint unsigned fx_m = 9600, fy_m = 9600, alt_min_m = 50;
  pose_t pending[$];
  pixel_t pixels_due[$];
  int tx_gap_max = 0, rx_gap_max = 0;
  bit tx_hold = 1'b0;
  int hold_req = 0;
  int n_sent = 0, n_checked = 0, n_bad = 0, n_stall_seen = 0;
  bit failed = 1'b0;

  always #4 clk_i = ~clk_i;

  ned_target_to_image_projection_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .goal_north_i(cur.gn), .goal_east_i(cur.ge),
    .craft_north_i(cur.cn), .craft_east_i(cur.ce),
    .heading_i(cur.hd), .height_i(cur.hgt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .image_x_o(img_x), .image_y_o(img_y)
  );

  function automatic logic [ntip_pkg::OUT_W-1:0] to_pixels(input longint comp,
                                                           input longint alt,
                                                           input longint unsigned focal);
    longint q;
    longint unsigned m, p;
    longint v;
    q = comp / alt;
    m = (q < 0) ? longint'(-q) : q;
    p = (m >> 30) * focal + (((m & (Q30_ONE - 1)) * focal) >> 30);
    if (q < 0) v = (p >= SAT_MAG) ? -SAT_MAG : -longint'(p);
    else v = (p > SAT_MAG - 1) ? SAT_MAG - 1 : longint'(p);
    return v[ntip_pkg::OUT_W-1:0];
  endfunction

  function automatic pixel_t project_pose(input pose_t p);
    logic [31:0] phase;
    logic [2:0] oct;
    longint unsigned a, x, x2, t, s0, c0;
    longint sn, cs, s, c, dn, de, fwd, rgt, flr, alt;
    pixel_t r;
    phase = {p.hd, 16'd0};
    oct = phase[31:29];
    a = oct[0] ? OCT_FULL - phase[28:0] : phase[28:0];
    x = (a * Q30_HPI) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE - x2 / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    s0 = (x * t) >> 30;
    t = Q30_ONE - x2 / 56;
    t = Q30_ONE - ((x2 * t) >> 30) / 30;
    t = Q30_ONE - ((x2 * t) >> 30) / 12;
    c0 = Q30_ONE - ((x2 * t) >> 30) / 2;
    s = s0;
    c = c0;
    case (oct)
      3'd0: begin sn = s;  cs = c;  end
      3'd1: begin sn = c;  cs = s;  end
      3'd2: begin sn = c;  cs = -s; end
      3'd3: begin sn = s;  cs = -c; end
      3'd4: begin sn = -s; cs = -c; end
      3'd5: begin sn = -c; cs = -s; end
      3'd6: begin sn = -c; cs = s;  end
      default: begin sn = -s; cs = c; end
    endcase
    dn = longint'(p.gn) - longint'(p.cn);
    de = longint'(p.ge) - longint'(p.ce);
    fwd = cs * dn + sn * de;
    rgt = cs * de - sn * dn;
    flr = (alt_min_m == 0) ? 1 : longint'(alt_min_m);
    alt = (longint'(p.hgt) > flr) ? longint'(p.hgt) : flr;
    r.x = to_pixels(rgt, alt, fx_m);
    r.y = to_pixels(fwd, alt, fy_m);
    return r;
  endfunction

  // request driver
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_stall) n_stall_seen++;
      if (in_valid && !in_stall) begin
        pixels_due.push_back(project_pose(cur));
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap > 0 || tx_hold || pending.size() == 0) begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap <= tx_gap - 1;
        end else begin
          cur <= pending.pop_front();
          in_valid <= 1'b1;
          tx_gap <= $urandom_range(0, tx_gap_max);
        end
      end
    end
  end

  // result monitor
  int rx_gap = 0, rx_hold = 0, hold_seen = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    bit stall_next;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          failed = 1'b1;
          n_bad++;
          if (n_bad <= 10) $display("unexpected result x=%0h y=%0h", img_x, img_y);
        end else begin
          want = pixels_due.pop_front();
          n_checked++;
          if (want.x !== img_x || want.y !== img_y) begin
            failed = 1'b1;
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp x=%0h y=%0h, got x=%0h y=%0h",
                       want.x, want.y, img_x, img_y);
          end
        end
        rx_gap = $urandom_range(0, rx_gap_max);
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_hold = 400;
      end
      stall_next = 1'b0;
      if (rx_hold > 0) begin
        rx_hold--;
        stall_next = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  task automatic reg_write(input logic [ntip_pkg::IDX_W-1:0] idx,
                           input logic [ntip_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      ntip_pkg::REG_FOCAL_X: fx_m = 64'(val);
      ntip_pkg::REG_FOCAL_Y: fy_m = 64'(val);
      ntip_pkg::REG_MIN_ALT: alt_min_m = 64'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid || pixels_due.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  function automatic pose_t rand_pose();
    pose_t p;
    logic signed [30:0] base_n, base_e;
    p.hd = 16'($urandom());
    if ($urandom_range(0, 3) == 0) begin
      p.gn = 31'($urandom()); p.ge = 31'($urandom());
      p.cn = 31'($urandom()); p.ce = 31'($urandom());
      p.hgt = 21'($urandom());
    end else begin
      base_n = 31'($urandom());
      base_e = 31'($urandom());
      base_n = base_n >>> $urandom_range(0, 12);
      base_e = base_e >>> $urandom_range(0, 12);
      p.cn = base_n;
      p.ce = base_e;
      p.gn = base_n + 31'($signed($urandom_range(0, 400000)) - 200000);
      p.ge = base_e + 31'($signed($urandom_range(0, 400000)) - 200000);
      p.hgt = $urandom_range(0, 4) == 0 ? 21'($signed($urandom_range(0, 200)) - 100)
                                         : 21'($urandom_range(1, 1048575));
    end
    return p;
  endfunction

  function automatic pose_t mk(input logic signed [30:0] gn, ge, cn, ce,
                               input logic [15:0] hd, input logic signed [20:0] h);
    pose_t p;
    p.gn = gn; p.ge = ge; p.cn = cn; p.ce = ce; p.hd = hd; p.hgt = h;
    return p;
  endfunction

  initial begin
    logic [15:0] corners [10] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000, 16'h8000,
                                 16'hA000, 16'hC000, 16'hE000, 16'hFFFF, 16'h1234};
    logic signed [30:0] pmax, pmin;
    pmax = 31'sh3FFF_FFFF;
    pmin = -31'sh4000_0000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corners[i])
      pending.push_back(mk(31'sd1000, 31'sd500, 31'sd0, 31'sd0, corners[i], 21'sd2000));
    pending.push_back(mk(pmax, pmax, pmin, pmin, 16'h1000, 21'sd1));
    pending.push_back(mk(pmin, pmin, pmax, pmax, 16'h9000, 21'sd1048575));
    pending.push_back(mk(pmax, pmin, pmin, pmax, 16'h5000, -21'sd1048576));
    pending.push_back(mk(31'sd700, -31'sd300, 31'sd700, -31'sd300, 16'h7777, 21'sd0));
    pending.push_back(mk(31'sd5000, 31'sd5000, 31'sd0, 31'sd0, 16'h0100, -21'sd5));
    pending.push_back(mk(-31'sd40, 31'sd90, 31'sd0, 31'sd0, 16'hC001, 21'sd49));
    pending.push_back(mk(pmax, 31'sd0, 31'sd0, 31'sd0, 16'h0000, 21'sd50));
    pending.push_back(mk(31'sd0, pmin, 31'sd0, 31'sd0, 16'h0000, 21'sd51));

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        1: begin
          reg_write(ntip_pkg::REG_FOCAL_X, 16'd0);
          reg_write(ntip_pkg::REG_FOCAL_Y, 16'd0);
          reg_write(ntip_pkg::REG_MIN_ALT, 16'd0);
        end
        2: begin
          reg_write(ntip_pkg::REG_FOCAL_X, 16'hFFFF);
          reg_write(ntip_pkg::REG_FOCAL_Y, 16'hFFFF);
          reg_write(ntip_pkg::REG_MIN_ALT, 16'hFFFF);
        end
        3: begin
          reg_write(ntip_pkg::REG_FOCAL_X, 16'd1);
          reg_write(ntip_pkg::REG_FOCAL_Y, 16'hFFFF);
          reg_write(ntip_pkg::REG_MIN_ALT, 16'd1);
        end
        4: begin
          reg_write(REG_UNUSED, 16'($urandom()));
          reg_write(ntip_pkg::REG_MIN_ALT, 16'd0);
        end
        5, 6: begin
          reg_write(ntip_pkg::REG_FOCAL_X, 16'($urandom()));
          reg_write(ntip_pkg::REG_FOCAL_Y, 16'($urandom()));
          reg_write(ntip_pkg::REG_MIN_ALT, 16'($urandom()));
        end
        default: ;
      endcase
      tx_gap_max = (ph % 3 == 0) ? 0 : 6;
      rx_gap_max = (ph % 2 == 0) ? 0 : 6;
      if (ph == 3) hold_req++;
      if (ph == 5) begin
        tx_hold = 1'b1;
        repeat (60) pending.push_back(rand_pose());
        tx_hold = 1'b0;
        while (pending.size() > 30) @(posedge clk_i);
        tx_hold = 1'b1;
        while (in_valid || pixels_due.size() != 0) @(posedge clk_i);
        tx_hold = 1'b0;
        repeat (70) pending.push_back(rand_pose());
      end else begin
        repeat (ph == 0 ? 110 : 130) pending.push_back(rand_pose());
      end
    end
    drain();

    $display("run: %0d requests, %0d results checked, %0d input stall cycles",
             n_sent, n_checked, n_stall_seen);
    $display("run: seven register settings incl. zero and full-scale, one long output hold");
    if (!failed && pixels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

### ned_target_to_image_projection_unit.f
rtl/ntip_pkg.sv
rtl/ntip_front.sv
rtl/ntip_sincos.sv
rtl/ntip_div.sv
rtl/ntip_back.sv
rtl/ned_target_to_image_projection_unit.sv
sim/tb_ned_target_to_image_projection_unit.sv
